@@ sv/gif_pkg.sv @@
// ----------------------------------------------------------------------------
// gif_pkg
// Shared types and constants for the GIF LZW decoder.
// ----------------------------------------------------------------------------
package gif_pkg;
  localparam int TableDepth = 4096;
  localparam int AddrW      = 12;
  localparam int CntW       = 13;

  typedef enum logic [2:0] {
    ST_PIXEL    = 3'd0,
    ST_NEED     = 3'd1,
    ST_CLEARED  = 3'd2,
    ST_END      = 3'd3,
    ST_BUSY     = 3'd4,
    ST_ACCEPTED = 3'd5
  } status_t;
endpackage

@@ sv/gif_lzw_decoder.sv @@
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// Streaming GIF LZW decoder with the string table held in block RAM.
// ----------------------------------------------------------------------------
// Each request gives one response. A byte write or an answer that carries
// only a status is given as the registered response. A pixel pop reads the
// stack RAM through its registered port in S_POP, then answers from S_OUT. A
// read that decodes a new code goes through a setup state (S_ADD), then walks
// the prefix chain one table entry per cycle through the registered RAM read
// port, pushing each byte on the stack; for KwKwK the last byte is pushed
// during setup. The new table entry is written at the end of the walk, once
// the first byte of the string is known. There is no clearing pass.
module gif_lzw_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,     // min_code_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // data_byte
  input  logic        in_tuser,      // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // [7:0] pixel, [10:8] status, rest zero
);
  import gif_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_WALK = 5'b00100,
    S_POP  = 5'b01000,
    S_OUT  = 5'b10000
  } fsm_t;

  // Table memories and pixel stack
  logic [AddrW-1:0] prefix_mem [TableDepth];
  logic [7:0]       suffix_mem [TableDepth];
  logic [7:0]       first_mem  [TableDepth];
  logic [7:0]       stack_mem  [TableDepth];

  fsm_t             state_r;
  logic [3:0]       min_r;
  logic [CntW-1:0]  sp_r;
  logic [18:0]      buf_r;
  logic [4:0]       bc_r;
  logic [CntW-1:0]  nfc_r;
  logic [3:0]       cw_r;
  logic [AddrW-1:0] prev_r;
  logic             prev_v_r;
  logic             ended_r;
  logic [7:0]       pix_r;
  logic [2:0]       stat_r;
  logic [AddrW-1:0] code_r;      // walk pointer
  logic [AddrW-1:0] cur_r;       // code being handled
  logic             kw_r;
  logic             pp_r;        // previous was valid at decode
  logic [7:0]       pf_r;        // first byte of previous string
  logic [12:0]      guard_r;
  logic [7:0]       rd_suf, rd_first, rd_stk;
  logic [AddrW-1:0] rd_pre;
  logic [AddrW-1:0] raddr;

  // Effective size, clear code
  logic [3:0]  esz;
  logic [12:0] cc;
  assign esz = (min_r < 4'd2) ? 4'd2 : ((min_r > 4'd8) ? 4'd8 : min_r);
  assign cc  = 13'd1 << esz;

  // Size taken on reset or register write
  logic [3:0] new_min, new_esz;
  assign new_min = rst_n ? cfg_wdata : 4'd8;
  assign new_esz = (new_min < 4'd2) ? 4'd2 : ((new_min > 4'd8) ? 4'd8 : new_min);

  logic [12:0] code;
  assign code = 13'(buf_r & ((19'd1 << cw_r) - 19'd1));

  logic acc;
  assign in_tready  = (state_r == S_IDLE) && !out_tvalid;
  assign acc        = in_tvalid && in_tready;
  assign out_tdata  = {5'd0, stat_r, pix_r};

  // Walk step: code still above the roots
  logic       step;
  logic [7:0] root;
  assign step = ({1'b0, code_r} >= cc) && (guard_r < 13'(TableDepth));
  assign root = ({1'b0, code_r} < cc) ? code_r[7:0] : 8'd0;

  // Single read-address mux for the table
  always_comb begin
    raddr = code_r;
    if (state_r == S_IDLE) raddr = prev_r;
    else if (state_r == S_ADD && kw_r) raddr = prev_r;
    else if (state_r == S_WALK && step) raddr = rd_pre;
  end

  // Table write controls
  logic tw_en; logic [AddrW-1:0] tw_a; logic [AddrW-1:0] tw_p;
  logic [7:0] tw_s, tw_f;
  logic sw_en; logic [AddrW-1:0] sw_a; logic [7:0] sw_d;
  logic [7:0] prev_first;
  assign prev_first = ({1'b0, prev_r} < cc) ? prev_r[7:0] : rd_first;

  // Memory ports
  always_ff @(posedge clk) begin
    rd_pre   <= prefix_mem[raddr];
    rd_suf   <= suffix_mem[raddr];
    rd_first <= first_mem[raddr];
    if (tw_en) begin
      prefix_mem[tw_a] <= tw_p;
      suffix_mem[tw_a] <= tw_s;
      first_mem[tw_a]  <= tw_f;
    end
    if (sw_en) stack_mem[sw_a] <= sw_d;
    rd_stk <= stack_mem[sp_r[AddrW-1:0]];
  end

  // Control
  logic [CntW-1:0] nfc_inc;
  assign nfc_inc = nfc_r + 13'd1;

  always_comb begin
    tw_en = 1'b0; tw_a = nfc_r[AddrW-1:0]; tw_p = prev_r; tw_f = pf_r;
    tw_s  = root;
    sw_en = 1'b0; sw_a = sp_r[AddrW-1:0]; sw_d = rd_suf;
    if (state_r == S_ADD && kw_r) begin
      sw_en = 1'b1;
      sw_d  = prev_first;
    end
    if (state_r == S_WALK) begin
      sw_d  = step ? rd_suf : root;
      sw_en = 1'b1;
      if (!step && pp_r && nfc_r < 13'(TableDepth)) tw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r <= S_IDLE;
      min_r <= new_min;
      sp_r <= '0; buf_r <= '0; bc_r <= '0; ended_r <= 1'b0;
      nfc_r <= (13'd1 << new_esz) + 13'd2; cw_r <= new_esz + 4'd1;
      prev_r <= '0; prev_v_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (acc) begin
          pix_r <= 8'd0;
          if (sp_r != '0 && in_tuser) begin
            state_r <= S_POP; sp_r <= sp_r - 13'd1;
          end else if (ended_r) begin
            stat_r <= ST_END; out_tvalid <= 1'b1;
          end else if (!in_tuser) begin
            if ({1'b0, bc_r} >= {1'b0, cw_r} || sp_r != '0) stat_r <= ST_BUSY;
            else begin
              buf_r <= (buf_r | (19'(in_tdata) << bc_r));
              bc_r  <= bc_r + 5'd8;
              stat_r <= ST_ACCEPTED;
            end
            out_tvalid <= 1'b1;
          end else if ({1'b0, bc_r} < {1'b0, cw_r}) begin
            stat_r <= ST_NEED; out_tvalid <= 1'b1;
          end else begin
            buf_r <= buf_r >> cw_r;
            bc_r  <= bc_r - {1'b0, cw_r};
            if (code == cc) begin
              nfc_r <= cc + 13'd2; cw_r <= esz + 4'd1;
              prev_r <= '0; prev_v_r <= 1'b0;
              stat_r <= ST_CLEARED; out_tvalid <= 1'b1;
            end else if (code == cc + 13'd1 || code > nfc_r ||
                         (code == nfc_r && (!prev_v_r || nfc_r >= 13'(TableDepth)))) begin
              ended_r <= 1'b1; stat_r <= ST_END; out_tvalid <= 1'b1;
            end else begin
              cur_r <= code[AddrW-1:0]; code_r <= code[AddrW-1:0];
              kw_r <= (code == nfc_r); pp_r <= prev_v_r;
              state_r <= S_ADD;
            end
          end
        end
        S_ADD: begin
          // first byte of prev is on rd_first; KwKwK pushes it and walks prev
          pf_r <= prev_first;
          guard_r <= {12'd0, kw_r};
          if (kw_r) begin
            sp_r   <= sp_r + 13'd1;
            code_r <= prev_r;
          end
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (step) begin
            code_r <= rd_pre; guard_r <= guard_r + 13'd1;
            sp_r <= sp_r + 13'd1;
          end else begin
            // root reached: new entry gets it as suffix
            if (pp_r && nfc_r < 13'(TableDepth)) begin
              nfc_r <= nfc_inc;
              if (cw_r < 4'd12 && nfc_inc == (13'd1 << cw_r) && nfc_inc < 13'(TableDepth))
                cw_r <= cw_r + 4'd1;
            end
            prev_r <= cur_r; prev_v_r <= 1'b1;
            state_r <= S_POP;
          end
        end
        S_POP: state_r <= S_OUT;
        S_OUT: begin
          pix_r <= rd_stk; stat_r <= ST_PIXEL; out_tvalid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // In the walk the read address is the link just read, so the RAM output
  // always belongs to the current code_r.

  // Assertions
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while working");
  a_bits: assert property (@(posedge clk) disable iff (!rst_n) bc_r <= 5'd19)
    else $error("bit count overflow");
endmodule
